FILE: rtl/core/dvr_pkg.sv
// ----------------------------------------------------------------------------
// dvr_pkg
// Shared types and constants for the distance-vector route table: table
// size, status and mode codes, the route record and the cell command bus.
// ----------------------------------------------------------------------------
package dvr_pkg;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W         = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] MODE_LOCAL = 2'd0;
  localparam logic [1:0] MODE_ADV   = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [7:0] LOCAL_COST = 8'd1;
  localparam logic [7:0] MAX_COST   = 8'd255;

  typedef enum logic [2:0] {
    ST_UNCHANGED = 3'd0,
    ST_IMPROVED  = 3'd1,
    ST_APPENDED  = 3'd2,
    ST_FULL      = 3'd3,
    ST_LOCAL     = 3'd4,
    ST_READ      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_UPDATE,
    S_READ
  } state_e;

  typedef struct packed {
    logic [31:0] addr;
    logic [5:0]  prefix;
    logic [7:0]  cost;
    logic [31:0] hop;
  } route_t;

  // Entry handed down the row, OR-combined from the one selected cell
  typedef struct packed {
    route_t           route;
    logic [IDX_W-1:0] idx;
  } bus_t;

  // Broadcast from the sequencer to every cell
  typedef struct packed {
    logic             search;
    logic             update;
    logic             improve_en;
    logic             append;
    logic             read_sel;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] slot;
    route_t           req;
  } cell_cmd_t;

endpackage

FILE: rtl/core/dvr_cell.sv
// ----------------------------------------------------------------------------
// dvr_cell
// One route table slot. Compares itself against the broadcast request,
// takes part in the first-hit priority chain and drives its entry onto the
// row bus when selected.
// ----------------------------------------------------------------------------
module dvr_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [dvr_pkg::IDX_W-1:0] idx_i,
  input  dvr_pkg::cell_cmd_t      cmd_i,
  input  logic                    claim_i,
  output logic                    claim_o,
  input  dvr_pkg::bus_t           bus_i,
  output dvr_pkg::bus_t           bus_o
);
  import dvr_pkg::*;

  route_t entry_q;
  logic   hit_q;
  logic   valid;
  logic   match;
  logic   pick;
  logic   sel;
  logic   improve;
  logic   append;
  bus_t   mine;

  assign valid = CNT_W'(idx_i) < cmd_i.count;
  assign match = valid && (entry_q.addr == cmd_i.req.addr)
                 && (entry_q.prefix == cmd_i.req.prefix);

  assign pick = (cmd_i.update && hit_q) || (cmd_i.read_sel && (idx_i == cmd_i.slot));
  // first picking cell along the row wins
  assign sel     = pick && !claim_i;
  assign claim_o = claim_i || pick;

  assign mine.route = entry_q;
  assign mine.idx   = idx_i;
  assign bus_o      = sel ? (bus_i | mine) : bus_i;

  assign improve = cmd_i.update && cmd_i.improve_en && sel
                   && (entry_q.cost > cmd_i.req.cost);
  assign append  = cmd_i.append && (CNT_W'(idx_i) == cmd_i.count);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q   <= 1'b0;
      entry_q <= '0;
    end else begin
      if (cmd_i.search) begin
        hit_q <= match;
      end
      if (append) begin
        entry_q <= cmd_i.req;
      end else if (improve) begin
        entry_q.cost <= cmd_i.req.cost;
        entry_q.hop  <= cmd_i.req.hop;
      end
    end
  end

endmodule

FILE: rtl/core/distance_vector_route_update_top.sv
// ----------------------------------------------------------------------------
// distance_vector_route_update_top
// Route table update: a row of table cells searched in parallel, with a
// sequencer that decides, writes and reads back the touched slot.
// ----------------------------------------------------------------------------
// Each accepted item passes through search, decide/write, read-back and idle;
//   the result is registered on leaving read-back, which waits while the output
//   register is stalled. The next item is taken only once the sequencer is back
//   in idle.
// Reset: asynchronous, clears the table to zero and the route count to zero.
module distance_vector_route_update_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] net_address_i,
  input  logic [5:0]  prefix_len_i,
  input  logic [7:0]  advertised_cost_i,
  input  logic [31:0] sender_ip_i,
  input  logic [3:0]  read_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [3:0]  entry_index_o,
  output logic [31:0] entry_address_o,
  output logic [5:0]  entry_prefix_o,
  output logic [7:0]  entry_cost_o,
  output logic [31:0] entry_next_hop_o,
  output logic [4:0]  entry_count_o
);
  import dvr_pkg::*;

  state_e           state_q, state_d;
  logic [1:0]       mode_q;
  route_t           req_q;
  logic [3:0]       ridx_q;
  logic [IDX_W-1:0] slot_q, slot_d;
  status_e          status_q, status_d;
  logic             show_q, show_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  logic             load_out;
  logic             accept;
  logic             full;
  logic             found;
  logic [7:0]       adv_cost;
  cell_cmd_t        cmd;
  logic             claim [TABLE_ENTRIES+1];
  bus_t             bus   [TABLE_ENTRIES+1];

  assign accept   = in_valid_i && !in_stall_o;
  assign full     = 32'(count_q) == TABLE_ENTRIES;
  assign found    = claim[TABLE_ENTRIES];
  assign adv_cost = (advertised_cost_i == MAX_COST) ? MAX_COST : advertised_cost_i + 8'd1;

  assign claim[0] = 1'b0;
  assign bus[0]   = '0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    dvr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (IDX_W'(i)),
      .cmd_i   (cmd),
      .claim_i (claim[i]),
      .claim_o (claim[i+1]),
      .bus_i   (bus[i]),
      .bus_o   (bus[i+1])
    );
  end

  always_comb begin
    state_d        = state_q;
    slot_d         = slot_q;
    status_d       = status_q;
    show_d         = show_q;
    count_d        = count_q;
    load_out       = 1'b0;
    cmd.search     = 1'b0;
    cmd.update     = 1'b0;
    cmd.improve_en = 1'b0;
    cmd.append     = 1'b0;
    cmd.read_sel   = 1'b0;
    cmd.count      = count_q;
    cmd.slot       = slot_q;
    cmd.req        = req_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        state_d    = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_d    = S_READ;
        status_d   = ST_UNCHANGED;
        show_d     = 1'b0;
        slot_d     = '0;
        case (mode_q)
          MODE_LOCAL: begin
            if (full) begin
              status_d = ST_FULL;
            end else begin
              cmd.append = 1'b1;
              status_d   = ST_LOCAL;
              show_d     = 1'b1;
              slot_d     = IDX_W'(count_q);
              count_d    = count_q + CNT_W'(1);
            end
          end
          MODE_ADV: begin
            if (req_q.addr != 32'd0) begin
              cmd.improve_en = 1'b1;
              if (found) begin
                show_d   = 1'b1;
                slot_d   = bus[TABLE_ENTRIES].idx;
                status_d = (bus[TABLE_ENTRIES].route.cost > req_q.cost) ? ST_IMPROVED
                                                                      : ST_UNCHANGED;
              end else if (full) begin
                status_d = ST_FULL;
              end else begin
                cmd.append = 1'b1;
                status_d   = ST_APPENDED;
                show_d     = 1'b1;
                slot_d     = IDX_W'(count_q);
                count_d    = count_q + CNT_W'(1);
              end
            end
          end
          MODE_READ: begin
            status_d = ST_READ;
            if (32'(ridx_q) < TABLE_ENTRIES) begin
              show_d = 1'b1;
              slot_d = IDX_W'(ridx_q);
            end
          end
          default: begin
            status_d = ST_UNCHANGED;
          end
        endcase
      end
      S_READ: begin
        cmd.read_sel = 1'b1;
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_UNCHANGED;
      show_q      <= 1'b0;
      slot_q      <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      status_q <= status_d;
      show_q   <= show_d;
      slot_q   <= slot_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q        <= mode_i;
      req_q.addr    <= net_address_i;
      req_q.prefix  <= prefix_len_i;
      req_q.cost    <= (mode_i == MODE_LOCAL) ? LOCAL_COST : adv_cost;
      req_q.hop     <= (mode_i == MODE_LOCAL) ? 32'd0 : sender_ip_i;
      ridx_q        <= read_index_i;
    end
    if (load_out) begin
      status_o         <= status_q;
      entry_index_o    <= show_q ? 4'(slot_q) : 4'd0;
      entry_address_o  <= show_q ? bus[TABLE_ENTRIES].route.addr   : 32'd0;
      entry_prefix_o   <= show_q ? bus[TABLE_ENTRIES].route.prefix : 6'd0;
      entry_cost_o     <= show_q ? bus[TABLE_ENTRIES].route.cost   : 8'd0;
      entry_next_hop_o <= show_q ? bus[TABLE_ENTRIES].route.hop    : 32'd0;
      entry_count_o    <= 5'(count_q);
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/core/dvr_checker.sv
// ----------------------------------------------------------------------------
// dvr_checker
// Port-level checks on the route table update block, bound to its top level.
// ----------------------------------------------------------------------------
module dvr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] status_o,
  input logic [3:0] entry_index_o,
  input logic [4:0] entry_count_o
);
  import dvr_pkg::*;

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(entry_index_o) && $stable(entry_count_o))
    else $error("stalled output item changed");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again while an item is in flight");

  // appended or loaded slot lies inside the table count
  a_append_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_APPENDED || status_o == ST_LOCAL)
      |-> entry_index_o < entry_count_o)
    else $error("appended slot outside the route count");

  // table full reported only with a full count and a cleared index
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL)
      |-> (32'(entry_count_o) == TABLE_ENTRIES) && (entry_index_o == 4'd0))
    else $error("table full flagged with room left");

endmodule

bind distance_vector_route_update_top dvr_checker u_dvr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .entry_index_o (entry_index_o),
  .entry_count_o (entry_count_o)
);
